/* rtl/core/ppacc_pkg.sv */
`timescale 1ns / 1ps
package ppacc_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int QONE_BITS   = 30;
    localparam int CFG_COUNT   = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int SQRT_STEPS  = 33;
    localparam int DIV_STEPS   = 31;
    localparam int CNT_W       = 6;
    localparam int OUT_SHIFT   = FRAC_BITS + QONE_BITS - 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SIGMA_CROSS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGMA_ONE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGMA_TWO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS_CROSS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS_ONE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS_TWO     = 3'd5;

    localparam logic [1:0] KIND_ONE = 2'd1;
    localparam logic [1:0] KIND_TWO = 2'd2;

    localparam logic [31:0] RST_SIGMA_CROSS = 32'd264261;
    localparam logic [31:0] RST_SIGMA_ONE   = 32'd288686;
    localparam logic [31:0] RST_SIGMA_TWO   = 32'd216269;
    localparam logic [31:0] RST_EPS_CROSS   = 32'd5894;
    localparam logic [31:0] RST_EPS_ONE     = 32'd12976;
    localparam logic [31:0] RST_EPS_TWO     = 32'd5243;

    typedef enum logic [2:0] {
        MS_DX, MS_DY, MS_DZ, MS_QQ, MS_Q2Q, MS_Q3Q3, MS_Q6Q3, MS_EPS
    } t_mul_sel;

    typedef enum logic [2:0] {
        WB_D2ADD, WB_Q2, WB_Q3, WB_Q6, WB_Q9
    } t_wb_sel;

    typedef struct packed {
        logic     load;
        logic     d2_clear;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     wb_en;
        t_wb_sel  wb_sel;
        logic     sqrt_init;
        logic     sqrt_step;
        logic     div_init;
        logic     div_step;
        logic     term;
        logic     acc;
        logic     set_ovl;
        logic     emit;
        logic     clear;
    } t_cmd;

    typedef struct packed {
        logic ovl_seen;
        logic last;
        logic ovl_now;
        logic r_zero;
        logic out_free;
    } t_status;

endpackage

/* rtl/core/ppacc_ctrl.sv */
`timescale 1ns / 1ps
module ppacc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  ppacc_pkg::t_status i_st,
    output ppacc_pkg::t_cmd    o_cmd
);
    import ppacc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_WX, S_WY, S_WZ, S_SQI, S_SQRT, S_CMP, S_DIV,
        S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_TERM, S_E1, S_E2, S_FIN
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                if (i_st.ovl_seen) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.d2_clear = 1'b1;
                    o_cmd.mul_en   = 1'b1;
                    o_cmd.mul_sel  = MS_DX;
                    n_state        = S_WX;
                end
            end
            S_WX: begin
                o_cmd.wb_en   = 1'b1;
                o_cmd.wb_sel  = WB_D2ADD;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_DY;
                n_state       = S_WY;
            end
            S_WY: begin
                o_cmd.wb_en   = 1'b1;
                o_cmd.wb_sel  = WB_D2ADD;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_DZ;
                n_state       = S_WZ;
            end
            S_WZ: begin
                o_cmd.wb_en  = 1'b1;
                o_cmd.wb_sel = WB_D2ADD;
                n_state      = S_SQI;
            end
            S_SQI: begin
                o_cmd.sqrt_init = 1'b1;
                n_cnt           = CNT_W'(SQRT_STEPS - 1);
                n_state         = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_cnt           = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (i_st.ovl_now) begin
                    o_cmd.set_ovl = 1'b1;
                    n_state       = S_FIN;
                end else if (i_st.r_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_cnt          = CNT_W'(DIV_STEPS - 1);
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_P1;
                end
            end
            S_P1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_QQ;
                n_state       = S_P2;
            end
            S_P2: begin
                o_cmd.wb_en  = 1'b1;
                o_cmd.wb_sel = WB_Q2;
                n_state      = S_P3;
            end
            S_P3: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_Q2Q;
                n_state       = S_P4;
            end
            S_P4: begin
                o_cmd.wb_en  = 1'b1;
                o_cmd.wb_sel = WB_Q3;
                n_state      = S_P5;
            end
            S_P5: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_Q3Q3;
                n_state       = S_P6;
            end
            S_P6: begin
                o_cmd.wb_en  = 1'b1;
                o_cmd.wb_sel = WB_Q6;
                n_state      = S_P7;
            end
            S_P7: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_Q6Q3;
                n_state       = S_P8;
            end
            S_P8: begin
                o_cmd.wb_en  = 1'b1;
                o_cmd.wb_sel = WB_Q9;
                n_state      = S_TERM;
            end
            S_TERM: begin
                o_cmd.term = 1'b1;
                n_state    = S_E1;
            end
            S_E1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_EPS;
                n_state       = S_E2;
            end
            S_E2: begin
                o_cmd.acc = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (!i_st.last) begin
                    n_state = S_IDLE;
                end else if (i_st.out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.clear = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    a_emit_only_at_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (r_state == S_FIN) && i_st.out_free)
        else $error("Result emitted outside the finish step.");

    a_load_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_START))
        else $error("Word load did not start the sequence.");

    a_no_acc_after_ovl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.set_ovl |=> !o_cmd.acc)
        else $error("Accumulation followed an overlap.");

endmodule

/* rtl/core/ppacc_dp.sv */
`timescale 1ns / 1ps
module ppacc_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ppacc_pkg::t_cmd                 i_cmd,
    output ppacc_pkg::t_status              o_st,
    input  logic                            i_cfg_we,
    input  logic [ppacc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                     i_cfg_data,
    input  logic signed [31:0]              i_first_x,
    input  logic signed [31:0]              i_first_y,
    input  logic signed [31:0]              i_first_z,
    input  logic [1:0]                      i_first_kind,
    input  logic signed [31:0]              i_second_x,
    input  logic signed [31:0]              i_second_y,
    input  logic signed [31:0]              i_second_z,
    input  logic [1:0]                      i_second_kind,
    input  logic                            i_last_pair,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [63:0]              o_energy,
    output logic                            o_overlap
);
    import ppacc_pkg::*;

    logic [31:0] r_cfg [CFG_COUNT];
    logic [32:0] r_dx, r_dy, r_dz;
    logic        r_last;
    logic [31:0] r_sigma, r_eps;
    logic [67:0] r_prod;
    logic [65:0] r_d2, r_rad;
    logic [35:0] r_rem;
    logic [32:0] r_root;
    logic [32:0] r_drem;
    logic [30:0] r_dsh, r_q, r_q2, r_q3;
    logic [31:0] r_q6;
    logic [32:0] r_q9;
    logic [34:0] r_mag;
    logic        r_neg;
    logic signed [63:0] r_sum;
    logic        r_ovl;
    logic        r_out_valid;
    logic signed [63:0] r_out_energy;
    logic        r_out_overlap;

    logic [32:0] n_dx, n_dy, n_dz;
    logic [31:0] n_sigma, n_eps;
    logic [34:0] mul_a;
    logic [32:0] mul_b;
    logic [35:0] sq_try, sq_trial;
    logic [33:0] dv_try;
    logic [35:0] root5, sig4, t_pos, t_sub, t_val;
    logic [53:0] c_mag;
    logic signed [55:0] c_val;
    logic signed [64:0] s_wide;

    function automatic logic [32:0] absdiff(input logic signed [31:0] a,
                                            input logic signed [31:0] b);
        logic signed [32:0] d;
        d = 33'(a) - 33'(b);
        return d[32] ? 33'(-d) : 33'(d);
    endfunction

    always_comb begin
        n_dx = absdiff(i_first_x, i_second_x);
        n_dy = absdiff(i_first_y, i_second_y);
        n_dz = absdiff(i_first_z, i_second_z);
        if (i_first_kind == i_second_kind && i_first_kind == KIND_ONE) begin
            n_sigma = r_cfg[CFG_SIGMA_ONE];
            n_eps   = r_cfg[CFG_EPS_ONE];
        end else if (i_first_kind == i_second_kind && i_first_kind == KIND_TWO) begin
            n_sigma = r_cfg[CFG_SIGMA_TWO];
            n_eps   = r_cfg[CFG_EPS_TWO];
        end else begin
            n_sigma = r_cfg[CFG_SIGMA_CROSS];
            n_eps   = r_cfg[CFG_EPS_CROSS];
        end
    end

    always_comb begin
        unique case (i_cmd.mul_sel)
            MS_DX: begin
                mul_a = {2'b0, r_dx};
                mul_b = r_dx;
            end
            MS_DY: begin
                mul_a = {2'b0, r_dy};
                mul_b = r_dy;
            end
            MS_DZ: begin
                mul_a = {2'b0, r_dz};
                mul_b = r_dz;
            end
            MS_QQ: begin
                mul_a = {4'b0, r_q};
                mul_b = {2'b0, r_q};
            end
            MS_Q2Q: begin
                mul_a = {4'b0, r_q2};
                mul_b = {2'b0, r_q};
            end
            MS_Q3Q3: begin
                mul_a = {4'b0, r_q3};
                mul_b = {2'b0, r_q3};
            end
            MS_Q6Q3: begin
                mul_a = {3'b0, r_q6};
                mul_b = {2'b0, r_q3};
            end
            MS_EPS: begin
                mul_a = r_mag;
                mul_b = {1'b0, r_eps};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        sq_try   = {r_rem[33:0], r_rad[65:64]};
        sq_trial = {1'b0, r_root, 2'b01};
        dv_try   = {r_drem, r_dsh[30]};
        root5    = {3'b0, r_root} + {1'b0, r_root, 2'b00};
        sig4     = {2'b0, r_sigma, 2'b00};
        t_pos    = {2'b0, r_q9, 1'b0};
        t_sub    = {3'b0, r_q6, 1'b0} + {4'b0, r_q6};
        t_val    = t_pos - t_sub;
        c_mag    = r_prod[OUT_SHIFT +: 54];
        c_val    = r_neg ? -$signed({2'b0, c_mag}) : $signed({2'b0, c_mag});
        s_wide   = 65'(r_sum) + 65'(c_val);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[CFG_SIGMA_CROSS] <= RST_SIGMA_CROSS;
            r_cfg[CFG_SIGMA_ONE]   <= RST_SIGMA_ONE;
            r_cfg[CFG_SIGMA_TWO]   <= RST_SIGMA_TWO;
            r_cfg[CFG_EPS_CROSS]   <= RST_EPS_CROSS;
            r_cfg[CFG_EPS_ONE]     <= RST_EPS_ONE;
            r_cfg[CFG_EPS_TWO]     <= RST_EPS_TWO;
        end else if (i_cfg_we && i_cfg_idx <= CFG_EPS_TWO) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum         <= '0;
            r_ovl         <= 1'b0;
            r_out_valid   <= 1'b0;
            r_last        <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_last <= i_last_pair;
            end
            if (i_cmd.set_ovl) begin
                r_ovl <= 1'b1;
            end
            if (i_cmd.acc) begin
                if (s_wide[64] != s_wide[63]) begin
                    r_sum <= s_wide[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
                end else begin
                    r_sum <= s_wide[63:0];
                end
            end
            if (i_cmd.clear) begin
                r_sum <= '0;
                r_ovl <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dx    <= n_dx;
            r_dy    <= n_dy;
            r_dz    <= n_dz;
            r_sigma <= n_sigma;
            r_eps   <= n_eps;
        end
        if (i_cmd.mul_en) begin
            r_prod <= 68'(mul_a) * 68'(mul_b);
        end
        if (i_cmd.d2_clear) begin
            r_d2 <= '0;
        end
        if (i_cmd.wb_en) begin
            unique case (i_cmd.wb_sel)
                WB_D2ADD: r_d2 <= r_d2 + r_prod[65:0];
                WB_Q2:    r_q2 <= r_prod[60:30];
                WB_Q3:    r_q3 <= r_prod[60:30];
                WB_Q6:    r_q6 <= r_prod[61:30];
                WB_Q9:    r_q9 <= r_prod[62:30];
                default:  r_q2 <= r_q2;
            endcase
        end
        if (i_cmd.sqrt_init) begin
            r_rad  <= r_d2;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_rad <= {r_rad[63:0], 2'b00};
            if (sq_try >= sq_trial) begin
                r_rem  <= sq_try - sq_trial;
                r_root <= {r_root[31:0], 1'b1};
            end else begin
                r_rem  <= sq_try;
                r_root <= {r_root[31:0], 1'b0};
            end
        end
        if (i_cmd.div_init) begin
            r_drem <= {2'b0, r_sigma[31:1]};
            r_dsh  <= {r_sigma[0], 30'b0};
            r_q    <= '0;
        end else if (i_cmd.div_step) begin
            r_dsh <= {r_dsh[29:0], 1'b0};
            if (dv_try >= {1'b0, r_root}) begin
                r_drem <= 33'(dv_try - {1'b0, r_root});
                r_q    <= {r_q[29:0], 1'b1};
            end else begin
                r_drem <= dv_try[32:0];
                r_q    <= {r_q[29:0], 1'b0};
            end
        end
        if (i_cmd.term) begin
            r_neg <= t_val[35];
            r_mag <= t_val[35] ? 35'(-t_val) : t_val[34:0];
        end
        if (i_cmd.emit) begin
            r_out_energy  <= r_ovl ? '0 : r_sum;
            r_out_overlap <= r_ovl;
        end
    end

    assign o_st.ovl_seen = r_ovl;
    assign o_st.last     = r_last;
    assign o_st.ovl_now  = root5 < sig4;
    assign o_st.r_zero   = (r_root == '0);
    assign o_st.out_free = !r_out_valid || !i_stall;

    assign o_valid   = r_out_valid;
    assign o_energy  = r_out_energy;
    assign o_overlap = r_out_overlap;

    a_ovl_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_overlap |-> r_out_energy == '0)
        else $error("Overlap word carries a non-zero energy.");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> r_out_valid)
        else $error("Emitted word not presented.");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> r_sum == '0 && !r_ovl)
        else $error("Running sum not cleared after the last pair.");

endmodule

/* rtl/core/pair_potential_9_6_accumulator.sv */
`timescale 1ns / 1ps
// A pair word skips the arithmetic if an earlier pair of the set overlapped, stops after the
// square root if the pair overlaps or its distance is zero, and runs the full sequence
// otherwise; a last pair waits further while the previous result word is still held. The time
// is set by the bit-serial square root (33 steps), division (31 steps) and the one shared
// multiplier that forms the squares, the powers of sigma over r and the product with epsilon.
module pair_potential_9_6_accumulator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ppacc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                     i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [31:0]              i_first_x,
    input  logic signed [31:0]              i_first_y,
    input  logic signed [31:0]              i_first_z,
    input  logic [1:0]                      i_first_kind,
    input  logic signed [31:0]              i_second_x,
    input  logic signed [31:0]              i_second_y,
    input  logic signed [31:0]              i_second_z,
    input  logic [1:0]                      i_second_kind,
    input  logic                            i_last_pair,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [63:0]              o_energy,
    output logic                            o_overlap
);
    import ppacc_pkg::*;

    t_cmd    cmd;
    t_status st;

    ppacc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    ppacc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_st          (st),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_first_x     (i_first_x),
        .i_first_y     (i_first_y),
        .i_first_z     (i_first_z),
        .i_first_kind  (i_first_kind),
        .i_second_x    (i_second_x),
        .i_second_y    (i_second_y),
        .i_second_z    (i_second_z),
        .i_second_kind (i_second_kind),
        .i_last_pair   (i_last_pair),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_energy      (o_energy),
        .o_overlap     (o_overlap)
    );

endmodule
